>>> src/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg: shared constants and types for the HSV to RGB converter
// Hue reduction constants, reciprocal multipliers and the sector code.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int FRAC_BITS_DEF = 12;   // Q1.12 default scale
  localparam int FIELD_W       = 13;   // saturation, brightness, r/g/b port width
  localparam int HUE_W         = 20;   // hue port width, 1/64 degree units

  localparam int HUE_FULL      = 23040; // 360 degrees
  localparam int HUE_SECTOR    = 3840;  // 60 degrees
  localparam int HH_W          = 15;    // reduced hue, < 23040
  localparam int DIFF_W        = 16;    // reduced hue before correction, < 46080
  localparam int REM_W         = 12;    // position within a sector, < 3840

  // floor(hue / 23040) estimate: (hue * 1456) >> 25, low by at most one
  localparam int HUE_RECIP     = 1456;
  localparam int HUE_RECIP_SH  = 25;
  localparam int HUE_PROD_W    = 31;
  localparam int QUOT_W        = 6;

  // floor(x / 15) for x < 2^20: (x * 1118482) >> 24, exact
  localparam int DIV15_RECIP   = 1118482;
  localparam int DIV15_SH      = 24;
  localparam int DIV15_W       = 21;
  localparam int DIV256_SH     = 8;     // 3840 = 256 * 15

  // item latency from accept to done strobe
  localparam int LATENCY       = 8;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

>>> src/h2r_hue_split.sv
// ----------------------------------------------------------------------------
// h2r_hue_split: hue reduction and sector split
// Clamps s and v, reduces hue mod 360 deg, splits into sector and fraction.
// Five register stages.
// ----------------------------------------------------------------------------
module h2r_hue_split #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [h2r_pkg::HUE_W-1:0]     hue,
  input  logic [h2r_pkg::FIELD_W-1:0]   saturation,
  input  logic [h2r_pkg::FIELD_W-1:0]   brightness,
  output logic                          out_valid,
  output h2r_pkg::sector_t              sector,
  output logic [FRAC_BITS:0]            frac,
  output logic [FRAC_BITS:0]            sat,
  output logic [FRAC_BITS:0]            val
);
  import h2r_pkg::*;

  localparam int W      = FRAC_BITS + 1;
  localparam int CMP_W  = (FIELD_W > W) ? FIELD_W : W;
  localparam int NUM_W  = FRAC_BITS + 4;
  localparam int FPR_W  = NUM_W + DIV15_W;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
  localparam int STAGES = 5;

  logic [STAGES-1:0] vld;
  logic [W-1:0]      sat_d [STAGES];
  logic [W-1:0]      val_d [STAGES];

  logic [HUE_W-1:0]  s1_hue;
  logic [QUOT_W-1:0] s1_quot;
  logic [DIFF_W-1:0] s2_diff;
  logic [HH_W-1:0]   s3_hh;
  sector_t           s4_sector;
  logic [REM_W-1:0]  s4_rem;
  sector_t           s5_sector;
  logic [W-1:0]      s5_frac;

  logic [CMP_W-1:0]      sat_x, val_x;
  logic [W-1:0]          sat_c, val_c;
  logic [HUE_PROD_W-1:0] hue_prod;
  logic [HUE_W-1:0]      diff_full;
  logic [HH_W-1:0]       hh_next;
  sector_t               sector_next;
  logic [REM_W-1:0]      rem_next;
  logic [NUM_W-1:0]      frac_num;
  logic [FPR_W-1:0]      frac_prod;

  // clamp to 1.0
  always_comb begin
    sat_x = CMP_W'(saturation);
    val_x = CMP_W'(brightness);
    sat_c = (sat_x > CMP_W'(ONE)) ? ONE : W'(sat_x);
    val_c = (val_x > CMP_W'(ONE)) ? ONE : W'(val_x);
  end

  assign hue_prod  = HUE_PROD_W'(hue) * HUE_PROD_W'(HUE_RECIP);
  assign diff_full = s1_hue - HUE_W'(s1_quot) * HUE_W'(HUE_FULL);

  // quotient estimate may be one low: one conditional subtract
  assign hh_next = (s2_diff >= DIFF_W'(HUE_FULL)) ? HH_W'(s2_diff - DIFF_W'(HUE_FULL))
                                                  : HH_W'(s2_diff);

  always_comb begin
    if (s3_hh >= HH_W'(5 * HUE_SECTOR)) begin
      sector_next = SEC_MAG_RED;
      rem_next    = REM_W'(s3_hh - HH_W'(5 * HUE_SECTOR));
    end else if (s3_hh >= HH_W'(4 * HUE_SECTOR)) begin
      sector_next = SEC_BLU_MAG;
      rem_next    = REM_W'(s3_hh - HH_W'(4 * HUE_SECTOR));
    end else if (s3_hh >= HH_W'(3 * HUE_SECTOR)) begin
      sector_next = SEC_CYN_BLU;
      rem_next    = REM_W'(s3_hh - HH_W'(3 * HUE_SECTOR));
    end else if (s3_hh >= HH_W'(2 * HUE_SECTOR)) begin
      sector_next = SEC_GRN_CYN;
      rem_next    = REM_W'(s3_hh - HH_W'(2 * HUE_SECTOR));
    end else if (s3_hh >= HH_W'(HUE_SECTOR)) begin
      sector_next = SEC_YEL_GRN;
      rem_next    = REM_W'(s3_hh - HH_W'(HUE_SECTOR));
    end else begin
      sector_next = SEC_RED_YEL;
      rem_next    = REM_W'(s3_hh);
    end
  end

  // f = (rem << FB) / 3840 = (rem << (FB-8)) / 15
  assign frac_num  = NUM_W'(s4_rem) << (FRAC_BITS - DIV256_SH);
  assign frac_prod = FPR_W'(frac_num) * FPR_W'(DIV15_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sat_d[0] <= sat_c;
    val_d[0] <= val_c;
    for (int i = 1; i < STAGES; i++) begin
      sat_d[i] <= sat_d[i-1];
      val_d[i] <= val_d[i-1];
    end
    s1_hue    <= hue;
    s1_quot   <= hue_prod[HUE_PROD_W-1:HUE_RECIP_SH];
    s2_diff   <= diff_full[DIFF_W-1:0];
    s3_hh     <= hh_next;
    s4_sector <= sector_next;
    s4_rem    <= rem_next;
    s5_sector <= s4_sector;
    s5_frac   <= W'(frac_prod[DIV15_SH+FRAC_BITS-1:DIV15_SH]);
  end

  assign out_valid = vld[STAGES-1];
  assign sector    = s5_sector;
  assign frac      = s5_frac;
  assign sat       = sat_d[STAGES-1];
  assign val       = val_d[STAGES-1];

  a_hh_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> s3_hh < HH_W'(HUE_FULL))
    else $error("reduced hue out of range");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> s4_rem < REM_W'(HUE_SECTOR))
    else $error("sector remainder out of range");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> s5_frac < ONE)
    else $error("fraction reached one");

endmodule

>>> src/h2r_pqt.sv
// ----------------------------------------------------------------------------
// h2r_pqt: p, q, t products
// Two multiplier stages: s*f terms and p, then q and t.
// ----------------------------------------------------------------------------
module h2r_pqt #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  h2r_pkg::sector_t   in_sector,
  input  logic [FRAC_BITS:0] frac,
  input  logic [FRAC_BITS:0] sat,
  input  logic [FRAC_BITS:0] val,
  output logic               out_valid,
  output h2r_pkg::sector_t   out_sector,
  output logic [FRAC_BITS:0] v_out,
  output logic [FRAC_BITS:0] p_out,
  output logic [FRAC_BITS:0] q_out,
  output logic [FRAC_BITS:0] t_out
);
  import h2r_pkg::*;

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic [1:0]  vld;
  sector_t     a_sector, b_sector;
  logic [W-1:0] a_v, a_p, a_sf, a_sfc;
  logic [W-1:0] b_v, b_p, b_q, b_t;

  logic [PW-1:0] sf_prod, sfc_prod, p_prod, q_prod, t_prod;

  // stage A: s*f, s*(1-f), v*(1-s); all results <= ONE
  assign sf_prod  = PW'(sat) * PW'(frac);
  assign sfc_prod = PW'(sat) * PW'(ONE - frac);
  assign p_prod   = PW'(val) * PW'(ONE - sat);

  // stage B
  assign q_prod = PW'(a_v) * PW'(ONE - a_sf);
  assign t_prod = PW'(a_v) * PW'(ONE - a_sfc);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    a_sector <= in_sector;
    a_v      <= val;
    a_sf     <= sf_prod[FRAC_BITS+W-1:FRAC_BITS];
    a_sfc    <= sfc_prod[FRAC_BITS+W-1:FRAC_BITS];
    a_p      <= p_prod[FRAC_BITS+W-1:FRAC_BITS];
    b_sector <= a_sector;
    b_v      <= a_v;
    b_p      <= a_p;
    b_q      <= q_prod[FRAC_BITS+W-1:FRAC_BITS];
    b_t      <= t_prod[FRAC_BITS+W-1:FRAC_BITS];
  end

  assign out_valid  = vld[1];
  assign out_sector = b_sector;
  assign v_out      = b_v;
  assign p_out      = b_p;
  assign q_out      = b_q;
  assign t_out      = b_t;

endmodule

>>> src/hsv_to_rgb_convert.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert: HSV to RGB color converter, one pixel per clock
// Hue in 1/64 degree, saturation and value in Q1.FRAC_BITS; RGB out in
// the same scale as value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive hue, saturation, brightness and raise start. The
//   item is taken at any edge with start high and busy low. busy is tied
//   low: the pipeline takes a new item every cycle.
//   Output channel: done pulses for one cycle with red, green, blue valid
//   during that cycle. The receiver has no way to stall; results must be
//   taken when done is high.
//   Throughput: one item per cycle, set by the fully pipelined datapath:
//   from the accepting edge to the result, each item passes 5 stages of
//   hue reduction and fraction, 2 multiplier stages and 1 output register.
//   Saturation and brightness above 1.0 are clamped to 1.0; hue of any
//   value is reduced modulo 360 degrees. Zero saturation gives grey.
//   Reset (rst, synchronous) clears all valid bits: items in flight are
//   dropped and done stays low until new items pass through.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [h2r_pkg::HUE_W-1:0]   hue,
  input  logic [h2r_pkg::FIELD_W-1:0] saturation,
  input  logic [h2r_pkg::FIELD_W-1:0] brightness,
  output logic                        done,
  output logic [h2r_pkg::FIELD_W-1:0] red,
  output logic [h2r_pkg::FIELD_W-1:0] green,
  output logic [h2r_pkg::FIELD_W-1:0] blue
);
  import h2r_pkg::*;

  localparam int W = FRAC_BITS + 1;

  // hue split -> products
  logic         hs_valid;
  sector_t      hs_sector;
  logic [W-1:0] hs_frac, hs_sat, hs_val;

  // products -> output select
  logic         pq_valid;
  sector_t      pq_sector;
  logic [W-1:0] pq_v, pq_p, pq_q, pq_t;

  logic [W-1:0] r_sel, g_sel, b_sel;

  assign busy = 1'b0;

  h2r_hue_split #(
    .FRAC_BITS (FRAC_BITS)
  ) u_hue_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (hs_valid),
    .sector     (hs_sector),
    .frac       (hs_frac),
    .sat        (hs_sat),
    .val        (hs_val)
  );

  h2r_pqt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pqt (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (hs_valid),
    .in_sector  (hs_sector),
    .frac       (hs_frac),
    .sat        (hs_sat),
    .val        (hs_val),
    .out_valid  (pq_valid),
    .out_sector (pq_sector),
    .v_out      (pq_v),
    .p_out      (pq_p),
    .q_out      (pq_q),
    .t_out      (pq_t)
  );

  // channel order per sector
  always_comb begin
    unique case (pq_sector)
      SEC_RED_YEL: begin r_sel = pq_v; g_sel = pq_t; b_sel = pq_p; end
      SEC_YEL_GRN: begin r_sel = pq_q; g_sel = pq_v; b_sel = pq_p; end
      SEC_GRN_CYN: begin r_sel = pq_p; g_sel = pq_v; b_sel = pq_t; end
      SEC_CYN_BLU: begin r_sel = pq_p; g_sel = pq_q; b_sel = pq_v; end
      SEC_BLU_MAG: begin r_sel = pq_t; g_sel = pq_p; b_sel = pq_v; end
      default:     begin r_sel = pq_v; g_sel = pq_p; b_sel = pq_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pq_valid;
    end
  end

  // output fields masked / extended to port width
  always_ff @(posedge clk) begin
    red   <= FIELD_W'(r_sel);
    green <= FIELD_W'(g_sel);
    blue  <= FIELD_W'(b_sel);
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("item did not reach output at expected latency");
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && saturation == '0) |-> ##LATENCY (red == green && green == blue))
    else $error("zero saturation did not give grey");
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done strobe right after reset");

endmodule

>>> tb/tb_hsv_to_rgb_convert.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_convert: self-checking bench for the HSV to RGB converter
// A queue of HSV items (directed corners, then random) feeds a clocked
// driver with random gaps; a clocked monitor checks every done strobe
// against an in-order queue of predicted RGB triples.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_convert;
  timeunit 1ns;
  timeprecision 1ps;

  import h2r_pkg::*;

  localparam int ONE          = 1 << FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1450;

  typedef struct {
    logic [HUE_W-1:0]   hue;
    logic [FIELD_W-1:0] sat;
    logic [FIELD_W-1:0] bri;
  } hsv_t;

  typedef struct {
    logic [FIELD_W-1:0] r;
    logic [FIELD_W-1:0] g;
    logic [FIELD_W-1:0] b;
  } rgb_t;

  // DUT ports; every input starts at a known value
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [HUE_W-1:0]   hue = '0;
  logic [FIELD_W-1:0] saturation = '0;
  logic [FIELD_W-1:0] brightness = '0;
  logic               done;
  logic [FIELD_W-1:0] red;
  logic [FIELD_W-1:0] green;
  logic [FIELD_W-1:0] blue;

  hsv_t hsv_pending[$];    // items not yet driven
  rgb_t rgb_expected[$];   // predicted colors, oldest first
  int   mismatches = 0;
  int   gap_left = 0;      // idle cycles before the next item
  int   burst_left = 0;    // items still to send back to back
  hsv_t next_item;

  hsv_to_rgb_convert u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted color for one HSV item. Saturation and value clamp to 1.0,
  // hue wraps at 360 degrees, and every product truncates.
  function automatic rgb_t predict_rgb(hsv_t item);
    int unsigned        s, v, hh, rem, f, p, q, t;
    logic [FIELD_W-1:0] vf, pf, qf, tf;
    sector_t            sec;
    rgb_t               res;
    s  = (item.sat > ONE) ? ONE : item.sat;
    v  = (item.bri > ONE) ? ONE : item.bri;
    vf = FIELD_W'(v);
    if (s == 0) begin
      // grey: all channels follow value
      res.r = vf;
      res.g = vf;
      res.b = vf;
    end else begin
      hh  = item.hue % HUE_FULL;
      sec = sector_t'(hh / HUE_SECTOR);
      rem = hh % HUE_SECTOR;
      f   = (rem << FRAC_BITS_DEF) / HUE_SECTOR;
      p   = (v * (ONE - s)) >> FRAC_BITS_DEF;
      q   = (v * (ONE - ((s * f) >> FRAC_BITS_DEF))) >> FRAC_BITS_DEF;
      t   = (v * (ONE - ((s * (ONE - f)) >> FRAC_BITS_DEF))) >> FRAC_BITS_DEF;
      pf  = FIELD_W'(p);
      qf  = FIELD_W'(q);
      tf  = FIELD_W'(t);
      case (sec)
        SEC_RED_YEL: begin res.r = vf; res.g = tf; res.b = pf; end
        SEC_YEL_GRN: begin res.r = qf; res.g = vf; res.b = pf; end
        SEC_GRN_CYN: begin res.r = pf; res.g = vf; res.b = tf; end
        SEC_CYN_BLU: begin res.r = pf; res.g = qf; res.b = vf; end
        SEC_BLU_MAG: begin res.r = tf; res.g = pf; res.b = vf; end
        default:     begin res.r = vf; res.g = pf; res.b = qf; end
      endcase
    end
    return res;
  endfunction

  // Idle length after an item: mostly none, some short, a few long,
  // with occasional back-to-back bursts.
  function automatic int next_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 5) burst_left = $urandom_range(80, 20);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Saturation / brightness: grey and full corners, over-range values
  // that must clamp, tiny values, and the general interior.
  function automatic logic [FIELD_W-1:0] rand_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8)  return '0;
    if (roll < 16) return FIELD_W'(ONE);
    if (roll < 26) return FIELD_W'($urandom_range((1 << FIELD_W) - 1, ONE + 1));
    if (roll < 32) return FIELD_W'($urandom_range(15, 1));
    return FIELD_W'($urandom_range(ONE - 1, 1));
  endfunction

  task automatic add_item(int unsigned h, int unsigned s, int unsigned b);
    hsv_t item;
    item.hue = HUE_W'(h);
    item.sat = FIELD_W'(s);
    item.bri = FIELD_W'(b);
    hsv_pending.push_back(item);
  endtask

  // Driver: an item is taken at an edge with start high and busy low.
  // The expectation is logged at that same edge, from the values held.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        next_item.hue = hue;
        next_item.sat = saturation;
        next_item.bri = brightness;
        rgb_expected.push_back(predict_rgb(next_item));
      end
      // a stalled item (busy high) holds its fields and start
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (hsv_pending.size() > 0) begin
          next_item = hsv_pending.pop_front();
          hue        <= next_item.hue;
          saturation <= next_item.sat;
          brightness <= next_item.bri;
          start      <= 1'b1;
          gap_left   <= next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: done marks a one-cycle result that cannot be held off.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (rgb_expected.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time, red, green, blue);
        mismatches++;
      end else begin
        rgb_t want;
        want = rgb_expected.pop_front();
        if (red !== want.r || green !== want.g || blue !== want.b) begin
          $display("%0t: mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                   $time, want.r, want.g, want.b, red, green, blue);
          mismatches++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned h, base;
    int          k;

    // directed: hue corners and wrap, each sector, level extremes
    add_item(0, ONE, ONE);
    add_item((1 << HUE_W) - 1, ONE, ONE);           // largest hue, wraps
    add_item(HUE_FULL - 1, ONE, ONE);               // just below 360 degrees
    add_item(HUE_FULL, ONE, ONE);                   // exactly 360 degrees
    for (k = 0; k < 6; k++) begin
      add_item(k * HUE_SECTOR + HUE_SECTOR / 2, 2500, 3000);   // mid sector
      add_item(k * HUE_SECTOR + HUE_SECTOR - 1, ONE, ONE);     // sector end
    end
    add_item(5000, 0, 3000);                        // grey
    add_item(5000, 0, (1 << FIELD_W) - 1);          // grey, value clamps
    add_item(9000, (1 << FIELD_W) - 1, 2000);       // saturation clamps
    add_item(9000, 1500, (1 << FIELD_W) - 1);       // value clamps
    add_item(12345, ONE, 0);                        // black
    add_item(17000, 1, 1);                          // smallest nonzero
    add_item(20000, ONE - 1, ONE - 1);

    // random part
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: h = $urandom_range((1 << HUE_W) - 1, 0);
        5, 6, 7:       h = $urandom_range(HUE_FULL - 1, 0);
        default: begin
          // near a sector edge, in some random turn of the wheel
          base = $urandom_range(5, 0) * HUE_SECTOR + $urandom_range(44, 0) * HUE_FULL;
          if (base > 3 && $urandom_range(1)) h = base - $urandom_range(3, 1);
          else h = base + $urandom_range(3, 0);
        end
      endcase
      add_item(h, rand_level(), rand_level());
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain: nothing left to send or to receive, then pipeline slack
    while (hsv_pending.size() > 0 || start || rgb_expected.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (rgb_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, rgb_expected.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> hsv_to_rgb_convert.f
src/h2r_pkg.sv
src/h2r_hue_split.sv
src/h2r_pqt.sv
src/hsv_to_rgb_convert.sv
tb/tb_hsv_to_rgb_convert.sv
